// ===== rtl/fnpll_pkg.sv =====
// ----------------------------------------------------------------------------
// fnpll_pkg
// Types, constants and the channel step table of the fractional-N divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

package fnpll_pkg;

  // request frequency limits in hertz
  localparam logic [32:0] FREQ_MIN  = 33'd35000000;
  localparam logic [32:0] FREQ_MAX  = 33'd4400000000;
  localparam logic [4:0]  STEP_TABLE_SIZE = 5'd16;

  // vco band edges used to pick the output divider and prescaler
  localparam logic [32:0] VCO_LOW   = 33'd2200000000;
  localparam logic [32:0] PRESC_LIM = 33'd3600000000;

  // divider limits
  localparam logic [28:0] MOD_MIN   = 29'd2;
  localparam logic [28:0] MOD_MAX   = 29'd4095;
  localparam logic [32:0] INT_MAX   = 33'd65535;
  localparam logic [32:0] INT_MIN_P0 = 33'd23;
  localparam logic [32:0] INT_MIN_P1 = 33'd75;

  // configuration register indexes
  localparam logic [2:0] CFG_REF_FREQ   = 3'd0;
  localparam logic [2:0] CFG_REF_DBL    = 3'd1;
  localparam logic [2:0] CFG_REF_CNT    = 3'd2;
  localparam logic [2:0] CFG_REF_HALF   = 3'd3;
  localparam logic [2:0] CFG_CLK_DIV    = 3'd4;
  localparam logic [2:0] CFG_BAND_DIV   = 3'd5;
  localparam logic [2:0] CFG_POWER      = 3'd6;

  typedef struct packed {
    logic [32:0] target_freq;
    logic [3:0]  step_index;
    logic [11:0] phase_word;
  } in_t;

  typedef struct packed {
    logic [31:0] reg_word;
    logic [2:0]  reg_index;
    logic        status;
    logic        last;
  } out_t;

  // channel step in hertz
  function automatic logic [18:0] step_hz(input logic [3:0] sel);
    logic [18:0] s;
    unique case (sel)
      4'd0:  s = 19'd1;
      4'd1:  s = 19'd5;
      4'd2:  s = 19'd8;
      4'd3:  s = 19'd10;
      4'd4:  s = 19'd20;
      4'd5:  s = 19'd50;
      4'd6:  s = 19'd100;
      4'd7:  s = 19'd500;
      4'd8:  s = 19'd1000;
      4'd9:  s = 19'd2500;
      4'd10: s = 19'd5000;
      4'd11: s = 19'd10000;
      4'd12: s = 19'd25000;
      4'd13: s = 19'd50000;
      4'd14: s = 19'd100000;
      default: s = 19'd500000;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/frac_n_pll_divider_setup.sv =====
// ----------------------------------------------------------------------------
// frac_n_pll_divider_setup
// Computes output divider, prescaler, INT, MOD and FRAC for a requested
// frequency and sends six packed control words, word 5 first, or one error word.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_ready is low until its last word has
// been transferred. All the arithmetic runs through one restoring divider
// that makes one quotient bit per cycle (29 + 33 + 29 + 60 bits, plus 29 + 29
// for the gcd reduction, which runs only when FRAC comes out nonzero), plus a
// binary gcd that removes at least one bit per cycle, a doubling search that
// picks the output divider, and one cycle per word on the output while
// out_ready is high.
// A request that fails an early range check answers with its single error
// word; one that fails the divider checks answers after the full computation.
`default_nettype none

module frac_n_pll_divider_setup import fnpll_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [27:0] cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SCALE = 12'b000000000010,
    S_PFD   = 12'b000000000100,
    S_INT   = 12'b000000001000,
    S_MOD   = 12'b000000010000,
    S_MUL   = 12'b000000100000,
    S_FRAC  = 12'b000001000000,
    S_GCD   = 12'b000010000000,
    S_FG    = 12'b000100000000,
    S_MG    = 12'b001000000000,
    S_CHECK = 12'b010000000000,
    S_EMIT  = 12'b100000000000
  } state_t;

  state_t state;

  // configuration
  logic [27:0] ref_freq;
  logic        ref_doubler;
  logic [9:0]  ref_counter;
  logic        ref_half;
  logic [11:0] clock_divider;
  logic [7:0]  band_select_div;
  logic [1:0]  power_level;

  // request and working values
  logic [3:0]  sidx;
  logic [11:0] phase;
  logic [32:0] num;
  logic [2:0]  divsel;
  logic        presc;
  logic [28:0] pfd;
  logic [32:0] nint;
  logic [28:0] rem;
  logic [28:0] modv;
  logic [28:0] frac;
  logic [57:0] prod;
  logic [28:0] ga;
  logic [28:0] gb;
  logic [4:0]  gk;
  logic [2:0]  idx;

  // shared divider
  logic [59:0] dvd;
  logic [29:0] dvs;
  logic [29:0] rem_q;
  logic [59:0] quo;
  logic [5:0]  cnt;
  logic [30:0] div_r;
  logic        div_ge;

  logic [10:0] den;
  logic [28:0] gval;
  logic        chk_bad;
  logic [2:0]  word_sel;
  logic [31:0] word_mux;

  assign in_ready = (state == S_IDLE);
  assign den      = ref_half ? {ref_counter, 1'b0} : {1'b0, ref_counter};
  assign gval     = 29'(ga << gk);

  // one restoring step
  assign div_r  = {rem_q, dvd[59]};
  assign div_ge = (div_r >= {1'b0, dvs});

  // final divider checks
  assign chk_bad = (modv < MOD_MIN) || (modv > MOD_MAX) || (frac > (modv - 29'd1)) ||
                   (nint > INT_MAX) || (nint < (presc ? INT_MIN_P1 : INT_MIN_P0));

  // control word for the next transfer
  assign word_sel = (state == S_CHECK) ? 3'd5 : (idx - 3'd1);

  always_comb begin
    word_mux = '0;
    unique case (word_sel)
      3'd0: word_mux = {1'b0, nint[15:0], frac[11:0], 3'd0};
      3'd1: word_mux = {4'd0, presc, phase, modv[11:0], 3'd1};
      3'd2: word_mux = {3'd0, 3'd6, ref_doubler, ref_half, ref_counter,
                        2'b00, 3'b111, (frac == '0) ? 2'b11 : 2'b00, 1'b1, 3'd0, 3'd2};
      3'd3: word_mux = {8'd0, 1'b1, (frac == '0) ? 2'b11 : 2'b00, 6'd0,
                        clock_divider, 3'd3};
      3'd4: word_mux = {8'd0, 1'b1, divsel, band_select_div, 6'd0, 1'b1,
                        power_level, 3'd4};
      3'd5: word_mux = {9'd0, 1'b1, 1'b0, 2'b11, 16'd0, 3'd5};
      default: word_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      cnt             <= '0;
      ref_freq        <= 28'd25000000;
      ref_doubler     <= 1'b0;
      ref_counter     <= 10'd25;
      ref_half        <= 1'b0;
      clock_divider   <= 12'd150;
      band_select_div <= 8'd80;
      power_level     <= 2'd0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_REF_FREQ: ref_freq        <= cfg_data;
          CFG_REF_DBL:  ref_doubler     <= cfg_data[0];
          CFG_REF_CNT:  ref_counter     <= cfg_data[9:0];
          CFG_REF_HALF: ref_half        <= cfg_data[0];
          CFG_CLK_DIV:  clock_divider   <= cfg_data[11:0];
          CFG_BAND_DIV: band_select_div <= cfg_data[7:0];
          CFG_POWER:    power_level     <= cfg_data[1:0];
          default: ;
        endcase
      end

      // divider iteration
      if (cnt != '0) begin
        rem_q <= div_ge ? 30'(div_r - {1'b0, dvs}) : div_r[29:0];
        quo   <= {quo[58:0], div_ge};
        dvd   <= {dvd[58:0], 1'b0};
        cnt   <= cnt - 6'd1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sidx   <= in_data.step_index;
            phase  <= in_data.phase_word;
            num    <= in_data.target_freq;
            divsel <= '0;
            if (in_data.target_freq > FREQ_MAX || in_data.target_freq < FREQ_MIN ||
                {1'b0, in_data.step_index} >= STEP_TABLE_SIZE) begin
              out_valid <= 1'b1;
              out_data  <= '{reg_word: '0, reg_index: '0, status: 1'b1, last: 1'b1};
              idx       <= '0;
              state     <= S_EMIT;
            end else begin
              state <= S_SCALE;
            end
          end
        end

        // output divider search, one doubling a cycle
        S_SCALE: begin
          if (divsel != 3'd7 && num <= VCO_LOW) begin
            num    <= {num[31:0], 1'b0};
            divsel <= divsel + 3'd1;
          end else begin
            presc <= (num > PRESC_LIM);
            if (den == '0) begin
              out_valid <= 1'b1;
              out_data  <= '{reg_word: '0, reg_index: '0, status: 1'b1, last: 1'b1};
              idx       <= '0;
              state     <= S_EMIT;
            end else begin
              dvd   <= {(ref_doubler ? {ref_freq, 1'b0} : {1'b0, ref_freq}), 31'd0};
              dvs   <= {19'd0, den};
              rem_q <= '0;
              cnt   <= 6'd29;
              state <= S_PFD;
            end
          end
        end

        S_PFD: begin
          if (cnt == '0) begin
            pfd <= quo[28:0];
            if (quo[28:0] == '0) begin
              out_valid <= 1'b1;
              out_data  <= '{reg_word: '0, reg_index: '0, status: 1'b1, last: 1'b1};
              idx       <= '0;
              state     <= S_EMIT;
            end else begin
              dvd   <= {num, 27'd0};
              dvs   <= {1'b0, quo[28:0]};
              rem_q <= '0;
              cnt   <= 6'd33;
              state <= S_INT;
            end
          end
        end

        S_INT: begin
          if (cnt == '0) begin
            nint  <= quo[32:0];
            rem   <= rem_q[28:0];
            dvd   <= {pfd, 31'd0};
            dvs   <= {11'd0, step_hz(sidx)};
            rem_q <= '0;
            cnt   <= 6'd29;
            state <= S_MOD;
          end
        end

        S_MOD: begin
          if (cnt == '0) begin
            modv  <= quo[28:0];
            prod  <= rem * quo[28:0];
            state <= S_MUL;
          end
        end

        // rounded frac: (2 * rem * mod + pfd) / (2 * pfd)
        S_MUL: begin
          dvd   <= {1'b0, prod, 1'b0} + {31'd0, pfd};
          dvs   <= {pfd, 1'b0};
          rem_q <= '0;
          cnt   <= 6'd60;
          state <= S_FRAC;
        end

        S_FRAC: begin
          if (cnt == '0) begin
            frac <= quo[28:0];
            if (quo[28:0] == '0) begin
              state <= S_CHECK;
            end else begin
              ga    <= quo[28:0];
              gb    <= modv;
              gk    <= '0;
              state <= S_GCD;
            end
          end
        end

        // binary gcd, one step a cycle
        S_GCD: begin
          if (ga == gb) begin
            dvd   <= {frac, 31'd0};
            dvs   <= {1'b0, gval};
            rem_q <= '0;
            cnt   <= 6'd29;
            state <= S_FG;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + 5'd1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga > gb) begin
            ga <= (ga - gb) >> 1;
          end else begin
            gb <= (gb - ga) >> 1;
          end
        end

        S_FG: begin
          if (cnt == '0) begin
            frac  <= quo[28:0];
            dvd   <= {modv, 31'd0};
            rem_q <= '0;
            cnt   <= 6'd29;
            state <= S_MG;
          end
        end

        S_MG: begin
          if (cnt == '0) begin
            modv  <= quo[28:0];
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          out_valid <= 1'b1;
          state     <= S_EMIT;
          if (chk_bad) begin
            out_data <= '{reg_word: '0, reg_index: '0, status: 1'b1, last: 1'b1};
            idx      <= '0;
          end else begin
            out_data <= '{reg_word: word_mux, reg_index: 3'd5, status: 1'b0, last: 1'b0};
            idx      <= 3'd5;
          end
        end

        // words go out from 5 down to 0
        S_EMIT: begin
          if (out_ready) begin
            if (idx == '0) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              idx      <= idx - 3'd1;
              out_data <= '{reg_word: word_mux, reg_index: idx - 3'd1, status: 1'b0,
                            last: (idx == 3'd1)};
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // results only leave from the emit state
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_EMIT)
    else $error("result valid outside emit state");

  // no new request while a result waits
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while result pending");

  // an error result is always the last one
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |-> out_data.last)
    else $error("error result not marked last");

  // divider runs only in a division state
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> (state == S_PFD || state == S_INT || state == S_MOD ||
                     state == S_FRAC || state == S_FG || state == S_MG))
    else $error("divider busy outside a division state");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Randomized check of the fractional-N divider setup. Requests go in through a
// valid/ready driver. Each request is predicted in integer arithmetic and
// turned into the six expected control words, or into the single error word.
// A monitor compares every output transfer with the oldest expected word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import fnpll_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [27:0] cfg_data;

  frac_n_pll_divider_setup dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // testbench copy of the setup registers
  logic [27:0] cur_ref_freq;
  logic        cur_ref_dbl;
  logic [9:0]  cur_ref_cnt;
  logic        cur_ref_half;
  logic [11:0] cur_clk_div;
  logic [7:0]  cur_band_div;
  logic [1:0]  cur_power;

  in_t  pending_requests[$];
  out_t expected_words[$];
  logic in_accepted;
  int   in_gap;
  int   out_stall;
  bit   burst_mode;
  bit   failed;
  int   cycle_count;

  localparam int CYCLE_LIMIT = 3000000;

  // channel step in hertz
  function automatic logic [63:0] channel_step(input logic [3:0] sel);
    logic [63:0] steps[16];
    steps = '{1, 5, 8, 10, 20, 50, 100, 500, 1000, 2500, 5000, 10000,
              25000, 50000, 100000, 500000};
    return steps[sel];
  endfunction

  function automatic out_t error_word();
    out_t o;
    o.reg_word = '0;
    o.reg_index = 3'd0;
    o.status = 1'b1;
    o.last = 1'b1;
    return o;
  endfunction

  // predict the control words of one request and queue them
  task automatic predict_control_words(input in_t req);
    logic [63:0] freq, step, ratio, outdiv, divsel, presc, den, pfd;
    logic [63:0] num, nint, rem, modv, frac, a, b, t;
    logic [31:0] words[6];
    out_t o;
    freq = 64'(req.target_freq);
    // range and table checks
    if (freq > 64'(FREQ_MAX) || freq < 64'(FREQ_MIN) || 5'(req.step_index) >= STEP_TABLE_SIZE) begin
      expected_words.push_back(error_word());
      return;
    end
    step = channel_step(req.step_index);
    // output divider and prescaler
    ratio = 64'd2200000000 / freq;
    outdiv = 1;
    divsel = 0;
    while (outdiv <= ratio && outdiv <= 64) begin
      outdiv = outdiv * 2;
      divsel = divsel + 1;
    end
    presc = (freq > 64'd3600000000 / outdiv) ? 1 : 0;
    // pfd; zero R counter or zero pfd is an error
    den = 64'(cur_ref_cnt) * (1 + 64'(cur_ref_half));
    if (den == 0) begin
      expected_words.push_back(error_word());
      return;
    end
    pfd = (64'(cur_ref_freq) * (1 + 64'(cur_ref_dbl))) / den;
    if (pfd == 0) begin
      expected_words.push_back(error_word());
      return;
    end
    num = freq * outdiv;
    nint = num / pfd;
    rem = num % pfd;
    modv = pfd / step;
    frac = (2 * rem * modv + pfd) / (2 * pfd);
    // reduce by gcd
    if (frac != 0) begin
      a = frac;
      b = modv;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      if (a > 1) begin
        frac = frac / a;
        modv = modv / a;
      end
    end
    // divider checks
    if (modv < 2 || modv > 4095 || frac > modv - 1 || nint > 65535 ||
        nint < (presc != 0 ? 64'd75 : 64'd23)) begin
      expected_words.push_back(error_word());
      return;
    end
    words[0] = 32'((frac << 3) | (nint << 15));
    words[1] = 32'(1 | (modv << 3) | (64'(req.phase_word) << 15) | (presc << 27));
    words[2] = 32'(2 | (1 << 6) | (frac == 0 ? (3 << 7) : 0) | (7 << 9)
             | (64'(cur_ref_cnt) << 14) | (64'(cur_ref_half) << 24)
             | (64'(cur_ref_dbl) << 25) | (6 << 26));
    words[3] = 32'(3 | (64'(cur_clk_div) << 3) | (frac == 0 ? (3 << 21) : 0)
             | (1 << 23));
    words[4] = 32'(4 | (64'(cur_power) << 3) | (1 << 5) | (64'(cur_band_div) << 12)
             | (divsel << 20) | (1 << 23));
    words[5] = 32'(5 | (3 << 19) | (1 << 22));
    for (int i = 5; i >= 0; i--) begin
      o.reg_word = words[i];
      o.reg_index = 3'(i);
      o.status = 1'b0;
      o.last = (i == 0);
      expected_words.push_back(o);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // request driver: new item or idle at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 19) == 0) burst_mode = ~burst_mode;
        in_gap <= burst_mode ? 0 : $urandom_range(0, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    out_t exp_w;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    in_accepted <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) predict_control_words(in_data);
    if (!rst && out_valid && out_ready) begin
      out_stall <= burst_mode ? 0 : $urandom_range(0, 14);
      if (expected_words.size() == 0) begin
        $error("unexpected word: reg_word %h reg_index %0d", out_data.reg_word,
               out_data.reg_index);
        failed = 1'b1;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_data.reg_word !== exp_w.reg_word) begin
          $error("reg_word expected %h actual %h", exp_w.reg_word, out_data.reg_word);
          failed = 1'b1;
        end
        if (out_data.reg_index !== exp_w.reg_index) begin
          $error("reg_index expected %0d actual %0d", exp_w.reg_index, out_data.reg_index);
          failed = 1'b1;
        end
        if (out_data.status !== exp_w.status) begin
          $error("status expected %0d actual %0d", exp_w.status, out_data.status);
          failed = 1'b1;
        end
        if (out_data.last !== exp_w.last) begin
          $error("last expected %0d actual %0d", exp_w.last, out_data.last);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [27:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_REF_FREQ: cur_ref_freq = val;
      CFG_REF_DBL:  cur_ref_dbl = val[0];
      CFG_REF_CNT:  cur_ref_cnt = val[9:0];
      CFG_REF_HALF: cur_ref_half = val[0];
      CFG_CLK_DIV:  cur_clk_div = val[11:0];
      CFG_BAND_DIV: cur_band_div = val[7:0];
      CFG_POWER:    cur_power = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic setup_regs(input logic [27:0] rf, input logic dbl, input logic [9:0] rc,
                            input logic hf, input logic [11:0] cd, input logic [7:0] bd,
                            input logic [1:0] pw);
    write_reg(CFG_REF_FREQ, rf);
    write_reg(CFG_REF_DBL, 28'(dbl));
    write_reg(CFG_REF_CNT, 28'(rc));
    write_reg(CFG_REF_HALF, 28'(hf));
    write_reg(CFG_CLK_DIV, 28'(cd));
    write_reg(CFG_BAND_DIV, 28'(bd));
    write_reg(CFG_POWER, 28'(pw));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_request(input logic [32:0] f, input logic [3:0] s, input logic [11:0] p);
    in_t r;
    r.target_freq = f;
    r.step_index = s;
    r.phase_word = p;
    pending_requests.push_back(r);
  endtask

  // mostly in-range requests spread over all output dividers, some noise
  task automatic add_random(input int n, input int min_step);
    logic [63:0] lo, hi, f;
    int k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, 7);
        hi = 64'd4400000000 >> k;
        lo = 64'd2200000000 >> k;
        if (lo < 64'd35000000) lo = 64'd35000000;
        f = lo + ({$urandom, $urandom} % (hi - lo + 1));
        if ($urandom_range(0, 7) == 0) f = f - (f % 1000000);
        add_request(33'(f), 4'($urandom_range(min_step, 15)), 12'($urandom));
      end else begin
        add_request(33'({$urandom, $urandom}), 4'($urandom), 12'($urandom));
      end
    end
  endtask

  // wait until every expected word has arrived
  task automatic drain();
    while (pending_requests.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REF_FREQ;
    cfg_data = '0;
    in_accepted = 1'b0;
    in_gap = 0;
    out_stall = 0;
    burst_mode = 1'b0;
    failed = 1'b0;
    cycle_count = 0;
    cur_ref_freq = 28'd25000000;
    cur_ref_dbl = 1'b0;
    cur_ref_cnt = 10'd25;
    cur_ref_half = 1'b0;
    cur_clk_div = 12'd150;
    cur_band_div = 8'd80;
    cur_power = 2'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests under reset settings (1 MHz pfd)
    add_request(33'(FREQ_MIN), 4'd8, 12'd0);
    add_request(33'(FREQ_MIN) - 33'd1, 4'd8, 12'd0);
    add_request(33'(FREQ_MAX), 4'd15, 12'd4095);
    add_request(33'(FREQ_MAX) + 33'd1, 4'd15, 12'd4095);
    add_request(33'd0, 4'd8, 12'd1);
    add_request(33'h1FFFFFFFF, 4'd15, 12'hAAA);
    add_request(33'd2000000000, 4'd11, 12'h555);
    add_request(33'd2200000000, 4'd10, 12'd7);
    add_request(33'd3600000000, 4'd12, 12'd9);
    add_request(33'd3600000001, 4'd12, 12'd9);
    add_request(33'd1234567891, 4'd0, 12'd3);
    add_request(33'd1234567891, 4'd7, 12'd3);
    add_request(33'd1234567891, 4'd9, 12'd3);
    add_request(33'd70000000, 4'd13, 12'd100);
    add_request(33'd137500000, 4'd14, 12'd200);
    add_request(33'd1100000000, 4'd8, 12'd300);
    add_random(70, 8);
    drain();

    // extreme settings: slow pfd, all fields but the reference frequency at maximum
    setup_regs(28'd250000000, 1'b1, 10'd1023, 1'b1, 12'd4095, 8'd255, 2'd3);
    add_random(80, 6);
    drain();

    // fast pfd, R counter, clock and band dividers at minimum; small INT values get rejected
    setup_regs(28'd250000000, 1'b1, 10'd1, 1'b0, 12'd0, 8'd0, 2'd1);
    add_random(50, 12);
    drain();

    // zero reference, then zero R counter
    setup_regs(28'd0, 1'b0, 10'd25, 1'b0, 12'd1000, 8'd17, 2'd2);
    add_random(10, 0);
    drain();
    setup_regs(28'hFFFFFFF, 1'b0, 10'd0, 1'b1, 12'd2222, 8'd128, 2'd1);
    add_random(10, 0);
    drain();

    // 10 MHz pfd
    setup_regs(28'd10000000, 1'b0, 10'd1, 1'b0, 12'd2730, 8'd170, 2'd2);
    add_random(90, 11);
    drain();

    // mid settings with divide by two
    setup_regs(28'd100000000, 1'b1, 10'd50, 1'b1, 12'd1365, 8'd85, 2'd3);
    add_random(90, 8);
    drain();

    // back to reset values
    setup_regs(28'd25000000, 1'b0, 10'd25, 1'b0, 12'd150, 8'd80, 2'd0);
    add_random(90, 8);
    drain();

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/fnpll_pkg.sv
rtl/frac_n_pll_divider_setup.sv
sim/testbench.sv
